@@ design/quadratic_root_solver_macros.svh @@
// assertion macros for the quadratic root solver
// used by the top level only, expects clk and rst_n in scope
`ifndef QUADRATIC_ROOT_SOLVER_MACROS_SVH
`define QUADRATIC_ROOT_SOLVER_MACROS_SVH
`ifndef SYNTHESIS
`define QRS_ASSERT(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("qrs check failed");
`define QRS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("qrs check failed");
`else
`define QRS_ASSERT(label, cond)
`define QRS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ design/qrs_pkg.sv @@
// shared types and constants for the quadratic root solver
// no dependencies
package qrs_pkg;

    localparam int SQ_STEPS = 25;
    localparam int RAD_W    = 2 * SQ_STEPS;
    localparam int REM_W    = SQ_STEPS + 3;
    localparam int NUM_W    = 35;
    localparam int DEN_W    = 17;
    localparam int DISC_W   = 34;

    typedef enum logic [1:0] {
        KIND_REAL    = 2'd0,
        KIND_COMPLEX = 2'd1,
        KIND_A_ZERO  = 2'd2
    } root_kind_t;

    typedef struct packed {
        logic signed [24:0]        nb;
        logic                      den_neg;
        logic [DEN_W-1:0]          den_mag;
        logic signed [DISC_W-1:0]  disc;
        root_kind_t                kind;
    } sq_side_t;

    typedef struct packed {
        logic [RAD_W-1:0]    rad;
        logic [REM_W-1:0]    rem;
        logic [SQ_STEPS-1:0] root;
        sq_side_t            side;
    } sq_data_t;

    typedef struct packed {
        logic [1:0]                q_neg;
        logic signed [DISC_W-1:0]  disc;
        root_kind_t                kind;
        logic [DEN_W-1:0]          den_mag;
    } dv_side_t;

    typedef struct packed {
        logic [1:0][DEN_W-1:0] rem;
        logic [1:0][NUM_W-1:0] num;
        dv_side_t              side;
    } dv_data_t;

endpackage

@@ design/qrs_sqrt_cell.sv @@
// one restoring square root step: brings down two radicand bits per beat
// depends on qrs_pkg
module qrs_sqrt_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              valid_in,
    input  qrs_pkg::sq_data_t data_in,
    output logic              valid_out,
    output qrs_pkg::sq_data_t data_out
);
    import qrs_pkg::*;

    logic              valid_reg;
    sq_data_t          data_reg;
    sq_data_t          data_next;
    logic [REM_W-1:0]  part;
    logic [REM_W-1:0]  trial;
    logic              fits;

    always_comb
    begin
        part  = {data_in.rem[REM_W-3:0], data_in.rad[RAD_W-1 -: 2]};
        trial = {1'b0, data_in.root, 2'b01};
        fits  = (part >= trial);
        data_next      = data_in;
        data_next.rad  = {data_in.rad[RAD_W-3:0], 2'b00};
        data_next.rem  = fits ? (part - trial) : part;
        data_next.root = {data_in.root[SQ_STEPS-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule

@@ design/qrs_div_cell.sv @@
// one restoring division step for both root lanes, one quotient bit per beat
// depends on qrs_pkg
module qrs_div_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              valid_in,
    input  qrs_pkg::dv_data_t data_in,
    output logic              valid_out,
    output qrs_pkg::dv_data_t data_out
);
    import qrs_pkg::*;

    logic             valid_reg;
    dv_data_t         data_reg;
    dv_data_t         data_next;
    logic [DEN_W-1:0] part [2];
    logic             fits [2];

    always_comb
    begin
        data_next = data_in;
        for (int i = 0; i < 2; i++)
        begin
            part[i] = {data_in.rem[i][DEN_W-2:0], data_in.num[i][NUM_W-1]};
            fits[i] = (part[i] >= data_in.side.den_mag);
            data_next.rem[i] = fits[i] ? (part[i] - data_in.side.den_mag) : part[i];
            data_next.num[i] = {data_in.num[i][NUM_W-2:0], fits[i]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule

@@ design/quadratic_root_solver.sv @@
// quadratic root solver top level: products, square root chain, divider chain
// depends on qrs_pkg, qrs_sqrt_cell, qrs_div_cell and the macros header
//
// channel  handshake               payload
// coef     coef_valid/coef_stall   coef_a, coef_b, coef_c (signed q8.8)
// root     root_valid/root_stall   root_one, root_two, discriminant, root_kind
//
// one beat per cycle while the chain is not held; stages: product stage, 25 root cells,
// 35 divider cells and the output register
// reset clears all valid bits, payload registers are left as they are
// a stalled result in the output register only holds the chain once the
// last divider cell also holds a beat; until then coefs keep being taken
`include "quadratic_root_solver_macros.svh"

module quadratic_root_solver (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               coef_valid,
    output logic               coef_stall,
    input  logic signed [15:0] coef_a,
    input  logic signed [15:0] coef_b,
    input  logic signed [15:0] coef_c,
    output logic               root_valid,
    input  logic               root_stall,
    output logic signed [31:0] root_one,
    output logic signed [31:0] root_two,
    output logic signed [33:0] discriminant,
    output logic [1:0]         root_kind
);
    import qrs_pkg::*;

    logic               en;
    logic               prod_valid_reg;
    logic signed [31:0] bb_reg;
    logic signed [31:0] ac_reg;
    logic signed [15:0] a_reg;
    logic signed [15:0] b_reg;

    logic signed [DISC_W-1:0] disc;
    logic [DISC_W-1:0]        disc_mag;
    logic [15:0]              a_mag;

    logic     sq_v [SQ_STEPS+1];
    sq_data_t sq_d [SQ_STEPS+1];
    logic     dv_v [NUM_W+1];
    dv_data_t dv_d [NUM_W+1];

    logic signed [26:0] s_ext;
    logic signed [26:0] nb_ext;
    logic signed [26:0] numer [2];
    logic [26:0]        numer_mag [2];
    sq_data_t           sq_last;

    dv_data_t           dv_last;
    logic [31:0]        root_val [2];
    logic [NUM_W-1:0]   qm [2];

    logic               out_load;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [31:0]        one_reg;
    logic [31:0]        two_reg;
    logic [DISC_W-1:0]  disc_reg;
    root_kind_t         kind_reg;

    assign en         = !(dv_v[NUM_W] && out_valid_reg && root_stall);
    assign coef_stall = !en;

    // product stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prod_valid_reg <= 1'b0;
        else if (en)
            prod_valid_reg <= coef_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bb_reg <= coef_b * coef_b;
            ac_reg <= coef_a * coef_c;
            a_reg  <= coef_a;
            b_reg  <= coef_b;
        end
    end

    always_comb
    begin
        disc     = {{2{bb_reg[31]}}, bb_reg} - ({{2{ac_reg[31]}}, ac_reg} <<< 2);
        disc_mag = disc[DISC_W-1] ? DISC_W'(-disc) : disc;
        a_mag    = a_reg[15] ? 16'(-a_reg) : a_reg;
        sq_d[0].rad          = {disc_mag, 16'b0};
        sq_d[0].rem          = '0;
        sq_d[0].root         = '0;
        sq_d[0].side.nb      = {-{b_reg[15], b_reg}, 8'b0};
        sq_d[0].side.den_neg = a_reg[15];
        sq_d[0].side.den_mag = {a_mag, 1'b0};
        sq_d[0].side.disc    = disc;
        priority if (a_reg == '0)
            sq_d[0].side.kind = KIND_A_ZERO;
        else if (disc[DISC_W-1])
            sq_d[0].side.kind = KIND_COMPLEX;
        else
            sq_d[0].side.kind = KIND_REAL;
    end
    assign sq_v[0] = prod_valid_reg;

    for (genvar k = 0; k < SQ_STEPS; k++)
    begin : g_sqrt
        qrs_sqrt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid_in  (sq_v[k]),
            .data_in   (sq_d[k]),
            .valid_out (sq_v[k+1]),
            .data_out  (sq_d[k+1])
        );
    end

    // numerators of both lanes, split into sign and magnitude
    always_comb
    begin
        sq_last = sq_d[SQ_STEPS];
        s_ext   = {2'b00, sq_last.root};
        nb_ext  = {{2{sq_last.side.nb[24]}}, sq_last.side.nb};
        if (sq_last.side.kind == KIND_COMPLEX)
        begin
            numer[0] = nb_ext;
            numer[1] = s_ext;
        end
        else
        begin
            numer[0] = nb_ext + s_ext;
            numer[1] = nb_ext - s_ext;
        end
        dv_d[0].side.disc    = sq_last.side.disc;
        dv_d[0].side.kind    = sq_last.side.kind;
        dv_d[0].side.den_mag = sq_last.side.den_mag;
        for (int i = 0; i < 2; i++)
        begin
            numer_mag[i] = numer[i][26] ? 27'(-numer[i]) : numer[i];
            dv_d[0].rem[i] = '0;
            dv_d[0].num[i] = {numer_mag[i][25:0], 8'b0, 1'b0} >> 1;
            dv_d[0].side.q_neg[i] = numer[i][26] ^ sq_last.side.den_neg;
        end
    end
    assign dv_v[0] = sq_v[SQ_STEPS];

    for (genvar k = 0; k < NUM_W; k++)
    begin : g_div
        qrs_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid_in  (dv_v[k]),
            .data_in   (dv_d[k]),
            .valid_out (dv_v[k+1]),
            .data_out  (dv_d[k+1])
        );
    end

    // sign, saturation and the zero-a override
    always_comb
    begin
        dv_last = dv_d[NUM_W];
        for (int i = 0; i < 2; i++)
        begin
            qm[i] = dv_last.num[i];
            if (dv_last.side.kind == KIND_A_ZERO)
                root_val[i] = '0;
            else if (dv_last.side.q_neg[i])
                root_val[i] = (qm[i] > NUM_W'(35'h080000000)) ? 32'h80000000
                                                              : 32'(-qm[i][31:0]);
            else
                root_val[i] = (qm[i] > NUM_W'(35'h07FFFFFFF)) ? 32'h7FFFFFFF
                                                              : qm[i][31:0];
        end
    end

    assign out_load       = dv_v[NUM_W] && (!out_valid_reg || !root_stall);
    assign out_valid_next = out_load ? 1'b1 : (out_valid_reg && root_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            one_reg  <= root_val[0];
            two_reg  <= root_val[1];
            disc_reg <= dv_last.side.disc;
            kind_reg <= dv_last.side.kind;
        end
    end

    assign root_valid   = out_valid_reg;
    assign root_one     = one_reg;
    assign root_two     = two_reg;
    assign discriminant = disc_reg;
    assign root_kind    = kind_reg;

    `QRS_ASSERT(a_zero_gives_zero, !(root_valid && root_kind == KIND_A_ZERO) || (root_one == '0 && root_two == '0))
    `QRS_ASSERT(complex_has_neg_disc, !(root_valid && root_kind == KIND_COMPLEX) || discriminant[33])
    `QRS_ASSERT(real_has_pos_disc, !(root_valid && root_kind == KIND_REAL) || !discriminant[33])
    `QRS_ASSERT(hold_only_when_full, !coef_stall || (root_valid && root_stall))
    `QRS_ASSERT_NEXT(held_result_stays, root_valid && root_stall, root_valid && $stable(root_one))

endmodule

@@ tb/quadratic_root_solver_checker.sv @@
// result checker for the quadratic root solver: predicts roots per coef beat
// depends on qrs_pkg for the root kind codes
module quadratic_root_solver_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               coef_valid,
    input  logic               coef_stall,
    input  logic signed [15:0] coef_a,
    input  logic signed [15:0] coef_b,
    input  logic signed [15:0] coef_c,
    input  logic               root_valid,
    input  logic               root_stall,
    input  logic signed [31:0] root_one,
    input  logic signed [31:0] root_two,
    input  logic signed [33:0] discriminant,
    input  logic [1:0]         root_kind,
    output int                 fail_count,
    output int                 pending_roots
);
    import qrs_pkg::*;

    typedef struct packed {
        logic signed [31:0] one;
        logic signed [31:0] two;
        logic signed [33:0] disc;
        root_kind_t         kind;
    } roots_t;

    roots_t expected_roots[$];

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    // sv division on longint truncates toward zero, as required
    function automatic roots_t solve_roots(logic signed [15:0] ca, logic signed [15:0] cb,
                                           logic signed [15:0] cc);
        roots_t r;
        longint a, b, c, d, den, nb, s;
        a = ca;
        b = cb;
        c = cc;
        d = b * b - 4 * a * c;
        r.one = '0;
        r.two = '0;
        r.disc = d[33:0];
        if (a == 0)
            r.kind = KIND_A_ZERO;
        else
        begin
            den = 2 * a;
            nb = -b * 256;
            s = longint'(int_sqrt(longint'(d < 0 ? -d : d) << 16));
            if (d < 0)
            begin
                r.kind = KIND_COMPLEX;
                r.one = clamp32((nb * 256) / den);
                r.two = clamp32((s * 256) / den);
            end
            else
            begin
                r.kind = KIND_REAL;
                r.one = clamp32(((nb + s) * 256) / den);
                r.two = clamp32(((nb - s) * 256) / den);
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch on %s: got %0d, expected %0d", what, got, want);
        fail_count++;
    endtask

    initial
    begin
        fail_count = 0;
        pending_roots = 0;
    end

    always @(posedge clk)
    begin
        roots_t w;
        if (rst_n)
        begin
            if (coef_valid && !coef_stall)
                expected_roots.push_back(solve_roots(coef_a, coef_b, coef_c));
            if (root_valid && !root_stall)
            begin
                if (expected_roots.size() == 0)
                    report_mismatch("unexpected result beat", 1, 0);
                else
                begin
                    w = expected_roots.pop_front();
                    if (root_one !== w.one)
                        report_mismatch("root_one", root_one, w.one);
                    if (root_two !== w.two)
                        report_mismatch("root_two", root_two, w.two);
                    if (discriminant !== w.disc)
                        report_mismatch("discriminant", discriminant, w.disc);
                    if (root_kind !== w.kind)
                        report_mismatch("root_kind", root_kind, w.kind);
                end
            end
            pending_roots = expected_roots.size();
        end
    end
endmodule

@@ tb/tb_quadratic_root_solver.sv @@
// stimulus and verdict for the quadratic root solver
// depends on quadratic_root_solver and quadratic_root_solver_checker
module tb_quadratic_root_solver;
    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               coef_valid = 1'b0;
    logic               coef_stall;
    logic signed [15:0] coef_a = '0;
    logic signed [15:0] coef_b = '0;
    logic signed [15:0] coef_c = '0;
    logic               root_valid;
    logic               root_stall = 1'b0;
    logic signed [31:0] root_one;
    logic signed [31:0] root_two;
    logic signed [33:0] discriminant;
    logic [1:0]         root_kind;
    int                 fail_count;
    int                 pending_roots;
    bit                 calm_tail = 0;

    localparam int DIRECTED = 22;
    localparam int RANDOM_N = 530;

    always #6 clk = ~clk;

    quadratic_root_solver i_dut (.*);

    quadratic_root_solver_checker i_checker (.*);

    function automatic logic [15:0] pick_coef();
        case ($urandom_range(0, 5))
            0: return 16'(16'sh8000 + $urandom_range(0, 3));
            1: return 16'(16'sh7fff - $urandom_range(0, 3));
            2: return 16'($urandom_range(0, 8) - 4);
            3: return 16'($urandom_range(0, 2047) - 1024);
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic send_coefs(logic [15:0] a, logic [15:0] b, logic [15:0] c);
        coef_valid <= 1'b1;
        coef_a <= a;
        coef_b <= b;
        coef_c <= c;
        @(posedge clk);
        while (coef_stall)
            @(posedge clk);
    endtask

    // sender gaps in bursts
    task automatic maybe_gap();
        if (!calm_tail && $urandom_range(0, 7) == 0)
        begin
            coef_valid <= 1'b0;
            repeat ($urandom_range(1, 12))
                @(posedge clk);
        end
    endtask

    // receiver stalls in bursts, none in the last part
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!calm_tail && $urandom_range(0, 5) == 0)
            begin
                root_stall <= 1'b1;
                repeat ($urandom_range(1, 12))
                    @(posedge clk);
                root_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        #3000000;
        $display("quadratic_root_solver test failed");
        $finish;
    end

    initial
    begin
        logic [15:0] dir_a[DIRECTED] = '{16'h0100, 16'h0100, 16'h0100, 16'h0000, 16'h0000,
            16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h0001, 16'hffff, 16'h0001,
            16'h8000, 16'hff00, 16'h0200, 16'h0100, 16'h7fff, 16'h0001, 16'h8000,
            16'hffff, 16'h0100, 16'h0001};
        logic [15:0] dir_b[DIRECTED] = '{16'hfd00, 16'h0200, 16'h0000, 16'h0300, 16'h8000,
            16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h0000,
            16'h0000, 16'h0400, 16'h0000, 16'h0000, 16'h0000, 16'h8000, 16'h8000,
            16'h7fff, 16'h0001, 16'hffff};
        logic [15:0] dir_c[DIRECTED] = '{16'h0200, 16'h0100, 16'h0100, 16'h0500, 16'h7fff,
            16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h0000, 16'h0000, 16'h7fff,
            16'h8000, 16'h0100, 16'hfe00, 16'h0000, 16'h7fff, 16'h8000, 16'h7fff,
            16'h8000, 16'h0001, 16'hffff};
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int i = 0; i < DIRECTED; i++)
            send_coefs(dir_a[i], dir_b[i], dir_c[i]);
        // drain fully once before the random part
        coef_valid <= 1'b0;
        while (pending_roots != 0)
            @(posedge clk);
        for (int i = 0; i < RANDOM_N; i++)
        begin
            if (i == RANDOM_N - 80)
                calm_tail = 1;
            maybe_gap();
            send_coefs(pick_coef(), pick_coef(), pick_coef());
        end
        coef_valid <= 1'b0;
        while (pending_roots != 0)
            @(posedge clk);
        repeat (70)
            @(posedge clk);
        if (fail_count == 0)
            $display("quadratic_root_solver test passed");
        else
            $display("quadratic_root_solver test failed");
        $finish;
    end
endmodule
